// ----- sv/md5id_pkg.sv -----
// ----------------------------------------------------------------------------
// md5id_pkg
// Shared types, constants and step tables for the iterated MD5 digest block.
// ----------------------------------------------------------------------------
package md5id_pkg;

    localparam int MD5ID_ITERATIONS_DEFAULT = 50;
    localparam int MD5ID_STEPS              = 64;
    localparam int MD5ID_WORD_W             = 32;
    localparam int MD5ID_WORDS              = 4;
    localparam int MD5ID_TDATA_W            = MD5ID_WORD_W * MD5ID_WORDS;

    localparam logic [31:0] MD5ID_IV_A = 32'h67452301;
    localparam logic [31:0] MD5ID_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5ID_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5ID_IV_D = 32'h10325476;

    // Fixed padding of the single 64-byte block: the pad bit in word 4 and
    // the bit length (128) in word 14.
    localparam logic [3:0]  MD5ID_PAD_IDX = 4'd4;
    localparam logic [3:0]  MD5ID_LEN_IDX = 4'd14;
    localparam logic [31:0] MD5ID_PAD_WORD = 32'h00000080;
    localparam logic [31:0] MD5ID_LEN_WORD = 32'd128;

    localparam logic [1:0] MD5ID_ROUND_F = 2'd0;
    localparam logic [1:0] MD5ID_ROUND_G = 2'd1;
    localparam logic [1:0] MD5ID_ROUND_H = 2'd2;
    localparam logic [1:0] MD5ID_ROUND_I = 2'd3;

    // Chaining value plus the four variable message words.
    typedef struct packed {
        logic [3:0][31:0] m;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [31:0]      d;
    } t_md5id_data;

    function automatic logic [31:0] step_const(input int i);
        logic [31:0] k;
        case (i)
            0:  k = 32'hd76aa478;  1: k = 32'he8c7b756;  2: k = 32'h242070db;
            3:  k = 32'hc1bdceee;  4: k = 32'hf57c0faf;  5: k = 32'h4787c62a;
            6:  k = 32'ha8304613;  7: k = 32'hfd469501;  8: k = 32'h698098d8;
            9:  k = 32'h8b44f7af; 10: k = 32'hffff5bb1; 11: k = 32'h895cd7be;
            12: k = 32'h6b901122; 13: k = 32'hfd987193; 14: k = 32'ha679438e;
            15: k = 32'h49b40821; 16: k = 32'hf61e2562; 17: k = 32'hc040b340;
            18: k = 32'h265e5a51; 19: k = 32'he9b6c7aa; 20: k = 32'hd62f105d;
            21: k = 32'h02441453; 22: k = 32'hd8a1e681; 23: k = 32'he7d3fbc8;
            24: k = 32'h21e1cde6; 25: k = 32'hc33707d6; 26: k = 32'hf4d50d87;
            27: k = 32'h455a14ed; 28: k = 32'ha9e3e905; 29: k = 32'hfcefa3f8;
            30: k = 32'h676f02d9; 31: k = 32'h8d2a4c8a; 32: k = 32'hfffa3942;
            33: k = 32'h8771f681; 34: k = 32'h6d9d6122; 35: k = 32'hfde5380c;
            36: k = 32'ha4beea44; 37: k = 32'h4bdecfa9; 38: k = 32'hf6bb4b60;
            39: k = 32'hbebfbc70; 40: k = 32'h289b7ec6; 41: k = 32'heaa127fa;
            42: k = 32'hd4ef3085; 43: k = 32'h04881d05; 44: k = 32'hd9d4d039;
            45: k = 32'he6db99e5; 46: k = 32'h1fa27cf8; 47: k = 32'hc4ac5665;
            48: k = 32'hf4292244; 49: k = 32'h432aff97; 50: k = 32'hab9423a7;
            51: k = 32'hfc93a039; 52: k = 32'h655b59c3; 53: k = 32'h8f0ccc92;
            54: k = 32'hffeff47d; 55: k = 32'h85845dd1; 56: k = 32'h6fa87e4f;
            57: k = 32'hfe2ce6e0; 58: k = 32'ha3014314; 59: k = 32'h4e0811a1;
            60: k = 32'hf7537e82; 61: k = 32'hbd3af235; 62: k = 32'h2ad7d2bb;
            63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input int i);
        logic [3:0] idx;
        logic [4:0] s;
        idx = {2'(i / 16), 2'(i & 3)};
        case (idx)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Message word index used by a given step.
    function automatic logic [3:0] msg_index(input int i);
        logic [3:0] g;
        case (2'(i / 16))
            MD5ID_ROUND_F: g = 4'(i & 15);
            MD5ID_ROUND_G: g = 4'((1 + 5 * i) & 15);
            MD5ID_ROUND_H: g = 4'((5 + 3 * i) & 15);
            MD5ID_ROUND_I: g = 4'((7 * i) & 15);
            default:       g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] msg_word(input logic [3:0][31:0] m,
                                             input logic [3:0] g);
        logic [31:0] w;
        case (g)
            4'd0:          w = m[0];
            4'd1:          w = m[1];
            4'd2:          w = m[2];
            4'd3:          w = m[3];
            MD5ID_PAD_IDX: w = MD5ID_PAD_WORD;
            MD5ID_LEN_IDX: w = MD5ID_LEN_WORD;
            default:       w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] round_func(input logic [1:0] rnd,
                                               input logic [31:0] b,
                                               input logic [31:0] c,
                                               input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            MD5ID_ROUND_F: f = d ^ (b & (c ^ d));
            MD5ID_ROUND_G: f = c ^ (d & (b ^ c));
            MD5ID_ROUND_H: f = b ^ c ^ d;
            MD5ID_ROUND_I: f = c ^ (b | ~d);
            default:       f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

// ----- sv/md5id_step.sv -----
// ----------------------------------------------------------------------------
// md5id_step
// One registered MD5 step; the step number fixes constant, rotation and word.
// ----------------------------------------------------------------------------
module md5id_step #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  md5id_pkg::t_md5id_data i_data,
    output logic                  o_valid,
    output md5id_pkg::t_md5id_data o_data
);
    import md5id_pkg::*;

    localparam logic [1:0]  ROUND = 2'(STEP / 16);
    localparam logic [31:0] K     = step_const(STEP);
    localparam logic [4:0]  S     = rot_amount(STEP);
    localparam logic [3:0]  G     = msg_index(STEP);

    logic [31:0]  w_f;
    logic [31:0]  w_t;
    t_md5id_data  n_data;
    t_md5id_data  r_data;
    logic         r_valid;

    always_comb begin
        w_f      = round_func(ROUND, i_data.b, i_data.c, i_data.d);
        w_t      = i_data.a + w_f + msg_word(i_data.m, G) + K;
        n_data   = i_data;
        n_data.a = i_data.d;
        n_data.d = i_data.c;
        n_data.c = i_data.b;
        n_data.b = i_data.b + rotl32(w_t, S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/md5id_pass.sv -----
// ----------------------------------------------------------------------------
// md5id_pass
// One full compression: 64 step stages, then a stage that adds the initial
// chaining value and reloads it for the next pass.
// ----------------------------------------------------------------------------
module md5id_pass (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  md5id_pkg::t_md5id_data i_data,
    output logic                  o_valid,
    output md5id_pkg::t_md5id_data o_data
);
    import md5id_pkg::*;

    logic        w_valid [0:MD5ID_STEPS];
    t_md5id_data w_data  [0:MD5ID_STEPS];
    t_md5id_data n_data;
    t_md5id_data r_data;
    logic        r_valid;

    assign w_valid[0] = i_valid;
    assign w_data[0]  = i_data;

    for (genvar g = 0; g < MD5ID_STEPS; g++) begin : g_step
        md5id_step #(
            .STEP (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Digest becomes the message of the next pass; chaining restarts at IV.
    always_comb begin
        n_data.m[0] = w_data[MD5ID_STEPS].a + MD5ID_IV_A;
        n_data.m[1] = w_data[MD5ID_STEPS].b + MD5ID_IV_B;
        n_data.m[2] = w_data[MD5ID_STEPS].c + MD5ID_IV_C;
        n_data.m[3] = w_data[MD5ID_STEPS].d + MD5ID_IV_D;
        n_data.a    = MD5ID_IV_A;
        n_data.b    = MD5ID_IV_B;
        n_data.c    = MD5ID_IV_C;
        n_data.d    = MD5ID_IV_D;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= w_valid[MD5ID_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/md5id_outq.sv -----
// ----------------------------------------------------------------------------
// md5id_outq
// Two-entry output queue; the pipeline advances while an entry is free.
// ----------------------------------------------------------------------------
module md5id_outq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [md5id_pkg::MD5ID_TDATA_W-1:0] i_data,
    output logic                                o_ready,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [md5id_pkg::MD5ID_TDATA_W-1:0] o_tdata
);
    import md5id_pkg::*;

    logic [1:0]               r_cnt;
    logic [1:0]               n_cnt;
    logic [MD5ID_TDATA_W-1:0] r_q0;
    logic [MD5ID_TDATA_W-1:0] r_q1;
    logic [MD5ID_TDATA_W-1:0] n_q0;
    logic [MD5ID_TDATA_W-1:0] n_q1;
    logic                     w_push;
    logic                     w_pop;

    assign o_ready  = (r_cnt != 2'd2);
    assign o_tvalid = (r_cnt != 2'd0);
    assign o_tdata  = r_q0;
    assign w_push   = i_valid && o_ready;
    assign w_pop    = o_tvalid && i_tready;

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
            if (r_cnt == 2'd0) begin
                n_q0 = i_data;
            end else begin
                n_q1 = i_data;
            end
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
            n_q0  = r_q1;
        end else if (w_pop && w_push) begin
            // head leaves, new transaction takes its place behind any second entry
            if (r_cnt == 2'd1) begin
                n_q0 = i_data;
            end else begin
                n_q0 = r_q1;
                n_q1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// ----- sv/md5_iterate_digest.sv -----
// ----------------------------------------------------------------------------
// md5_iterate_digest
// Iterated MD5 of a 16-byte value, fully unrolled into a step pipeline.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit first)                 Meaning
// s_axis   in   in_word0, in_word1, in_word2, in_word3 16-byte value, LE words
// m_axis   out  out_word0 .. out_word3 (A, B, C, D)    final digest, LE words
//
// One transaction is accepted per cycle while o_s_axis_tready is high. Each pass
// is 64 step stages plus one chaining-add stage; the output queue registers the result.
// Reset clears the valid bits of every stage and empties the output queue.
// The whole pipeline holds only while two results wait in the output queue;
// with the downstream ready, the pipeline never stalls.
// ----------------------------------------------------------------------------
module md5_iterate_digest #(
    parameter int ITERATIONS = md5id_pkg::MD5ID_ITERATIONS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // in_word0 [31:0], in_word1 [63:32], in_word2 [95:64], in_word3 [127:96]
    input  logic [md5id_pkg::MD5ID_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_word0 [31:0], out_word1 [63:32], out_word2 [95:64], out_word3 [127:96]
    output logic [md5id_pkg::MD5ID_TDATA_W-1:0] o_m_axis_tdata
);
    import md5id_pkg::*;

    logic        w_en;
    logic        w_valid [0:ITERATIONS];
    t_md5id_data w_data  [0:ITERATIONS];

    assign w_valid[0] = i_s_axis_tvalid;

    always_comb begin
        w_data[0].m = i_s_axis_tdata;
        w_data[0].a = MD5ID_IV_A;
        w_data[0].b = MD5ID_IV_B;
        w_data[0].c = MD5ID_IV_C;
        w_data[0].d = MD5ID_IV_D;
    end

    for (genvar p = 0; p < ITERATIONS; p++) begin : g_pass
        md5id_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[p]),
            .i_data  (w_data[p]),
            .o_valid (w_valid[p+1]),
            .o_data  (w_data[p+1])
        );
    end

    md5id_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[ITERATIONS]),
        .i_data   (w_data[ITERATIONS].m),
        .o_ready  (w_en),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = w_en;

endmodule
